// ===== rtl/pfo_pkg.sv =====
// shared types, codes and default sizes for the position fix odometer
`timescale 1ns / 1ps
package pfo_pkg;

	// default sizes
	localparam int PFO_POS_WIDTH  = 24;
	localparam int PFO_ACC_WIDTH  = 48;
	localparam int PFO_TICK_WIDTH = 16;

	// configuration port
	localparam int PFO_ADDR_WIDTH = 4;
	localparam int PFO_DATA_WIDTH = 32;

	// register indexes
	typedef enum logic [1:0] {
		REG_DEPTH_LIMIT = 2'd0,
		REG_STALE_LIMIT = 2'd1,
		REG_ALT_ENABLE  = 2'd2,
		REG_ALT_MULT    = 2'd3
	} pfo_reg_t;

	// input item actions
	typedef enum logic [1:0] {
		ACT_X     = 2'd0,
		ACT_Y     = 2'd1,
		ACT_DEPTH = 2'd2,
		ACT_TICK  = 2'd3
	} pfo_action_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_SUM,
		ST_ROOT,
		ST_ACC,
		ST_ALT_LO,
		ST_ALT_HI,
		ST_ALT_SUM,
		ST_FIN
	} pfo_state_t;

	// fixed-width configuration fields
	typedef struct packed {
		logic [15:0] stale_limit;
		logic        alt_enable;
		logic [15:0] alt_mult;
	} pfo_cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic apply;
		logic sq_x;
		logic sq_y;
		logic sum;
		logic root_step;
		logic acc;
		logic alt_lo;
		logic alt_hi;
		logic alt_sum;
		logic load_out;
	} pfo_cmd_t;

endpackage

// ===== rtl/pfo_regs.sv =====
// configuration registers behind the apb-style port
`timescale 1ns / 1ps
module pfo_regs #(
	parameter int POS_WIDTH = pfo_pkg::PFO_POS_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pfo_pkg::PFO_ADDR_WIDTH-1:0]  paddr,
	input  logic [pfo_pkg::PFO_DATA_WIDTH-1:0]  pwdata,
	output logic [pfo_pkg::PFO_DATA_WIDTH-1:0]  prdata,
	output logic                                pready,
	output logic signed [POS_WIDTH-1:0]         depth_limit,
	output pfo_pkg::pfo_cfg_t                   cfg
);
	import pfo_pkg::*;

	logic signed [POS_WIDTH-1:0] depth_limit_q;
	pfo_cfg_t                    cfg_q;
	logic                        wr_en;
	pfo_reg_t                    reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = pfo_reg_t'(paddr[3:2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_limit_q     <= '0;
			cfg_q.stale_limit <= 16'd10;
			cfg_q.alt_enable  <= 1'b0;
			cfg_q.alt_mult    <= 16'd256;
		end else if (wr_en) begin
			case (reg_sel)
				REG_DEPTH_LIMIT: depth_limit_q     <= pwdata[POS_WIDTH-1:0];
				REG_STALE_LIMIT: cfg_q.stale_limit <= pwdata[15:0];
				REG_ALT_ENABLE:  cfg_q.alt_enable  <= pwdata[0];
				REG_ALT_MULT:    cfg_q.alt_mult    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// readback, depth threshold sign extended
	always_comb begin
		case (reg_sel)
			REG_DEPTH_LIMIT: prdata = PFO_DATA_WIDTH'(depth_limit_q);
			REG_STALE_LIMIT: prdata = PFO_DATA_WIDTH'(cfg_q.stale_limit);
			REG_ALT_ENABLE:  prdata = PFO_DATA_WIDTH'(cfg_q.alt_enable);
			REG_ALT_MULT:    prdata = PFO_DATA_WIDTH'(cfg_q.alt_mult);
			default:         prdata = '0;
		endcase
	end

	assign depth_limit = depth_limit_q;
	assign cfg         = cfg_q;

endmodule

// ===== rtl/pfo_ctrl.sv =====
// controller state machine sequencing one item through the datapath
`timescale 1ns / 1ps
module pfo_ctrl #(
	parameter int POS_WIDTH = pfo_pkg::PFO_POS_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              leg_now,
	output pfo_pkg::pfo_cmd_t cmd
);
	import pfo_pkg::*;

	localparam int ROOT_BITS = POS_WIDTH + 1;
	localparam int CNT_W     = $clog2(ROOT_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_BITS - 1);

	pfo_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_full_q;
	logic             accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_full_q;

	// state, iteration counter and output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.load_out) begin
				out_full_q <= 1'b1;
			end else if (out_ready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.apply = 1'b1;
					state_d   = leg_now ? ST_SQX : ST_ALT_LO;
				end
			end
			ST_SQX: begin
				cmd.sq_x = 1'b1;
				state_d  = ST_SQY;
			end
			ST_SQY: begin
				cmd.sq_y = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				cnt_d   = '0;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_ALT_LO;
			end
			ST_ALT_LO: begin
				cmd.alt_lo = 1'b1;
				state_d    = ST_ALT_HI;
			end
			ST_ALT_HI: begin
				cmd.alt_hi = 1'b1;
				state_d    = ST_ALT_SUM;
			end
			ST_ALT_SUM: begin
				cmd.alt_sum = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				// hold while the previous result is still waiting
				if (!out_full_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// a result never overwrites one that has not been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_full_q || out_ready))
		else $error("result register overwritten");

	// an item that completes a leg goes to the square root path
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && leg_now) |=> (state_q == ST_SQX))
		else $error("leg item skipped the square root");

	// the root starts its iterations from a cleared count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |=> (state_q == ST_ROOT && cnt_q == '0))
		else $error("root iteration count not cleared");

endmodule

// ===== rtl/pfo_dp.sv =====
// datapath: fix state, squares, bit-serial root, accumulators and scaling
`timescale 1ns / 1ps
module pfo_dp #(
	parameter int POS_WIDTH  = pfo_pkg::PFO_POS_WIDTH,
	parameter int ACC_WIDTH  = pfo_pkg::PFO_ACC_WIDTH,
	parameter int TICK_WIDTH = pfo_pkg::PFO_TICK_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pfo_pkg::pfo_cmd_t           cmd,
	input  logic signed [POS_WIDTH-1:0] depth_limit,
	input  pfo_pkg::pfo_cfg_t           cfg,
	input  logic [1:0]                  action,
	input  logic signed [POS_WIDTH-1:0] value,
	output logic                        leg_now,
	output logic                        leg_valid,
	output logic [POS_WIDTH:0]          leg_len,
	output logic [ACC_WIDTH-1:0]        total_dist,
	output logic [ACC_WIDTH-1:0]        depth_dist,
	output logic [ACC_WIDTH-1:0]        alt_total,
	output logic                        stale
);
	import pfo_pkg::*;

	localparam int R    = POS_WIDTH + 1;
	localparam int RW   = 2 * R;
	localparam int SQW  = 2 * POS_WIDTH;
	localparam int CMPW = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;
	localparam logic [63:0] ACC_MAX64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - ACC_WIDTH);

	// fix state
	logic signed [POS_WIDTH-1:0] x_now_q, y_now_q, x_prev_q, y_prev_q, depth_now_q;
	logic                        have_x_q, have_y_q, first_pair_q, fix_seen_q;
	logic [TICK_WIDTH-1:0]       idle_ticks_q;
	logic [ACC_WIDTH-1:0]        total_q, deep_q, alt_q;
	logic                        leg_q;

	// working registers
	logic [POS_WIDTH-1:0] dx_q, dy_q;
	logic [SQW-1:0]       sqx_q, sqy_q;
	logic [RW-1:0]        rad_q;
	logic [R:0]           rem_q;
	logic [R-1:0]         root_q;
	logic [47:0]          plo_q, phi_q;

	// next values of the fix state for the item being accepted
	logic signed [POS_WIDTH-1:0] x_n, y_n;
	logic                        hx_n, hy_n;
	logic                        pair;
	logic signed [POS_WIDTH:0]   ddx, ddy;

	function automatic logic [ACC_WIDTH-1:0] sat_add(
		input logic [ACC_WIDTH-1:0] a,
		input logic [R-1:0]         b
	);
		logic [ACC_WIDTH:0] s;
		s = {1'b0, a} + (ACC_WIDTH+1)'(b);
		return s[ACC_WIDTH] ? '1 : s[ACC_WIDTH-1:0];
	endfunction

	always_comb begin
		x_n  = x_now_q;
		y_n  = y_now_q;
		hx_n = have_x_q;
		hy_n = have_y_q;
		case (pfo_action_t'(action))
			ACT_X: begin
				x_n  = value;
				hx_n = 1'b1;
			end
			ACT_Y: begin
				y_n  = value;
				hy_n = 1'b1;
			end
			default: ;
		endcase
		pair    = hx_n && hy_n;
		leg_now = pair && !first_pair_q;
		ddx     = (POS_WIDTH+1)'(x_n) - (POS_WIDTH+1)'(x_prev_q);
		ddy     = (POS_WIDTH+1)'(y_n) - (POS_WIDTH+1)'(y_prev_q);
	end

	// apply the item, accumulate, keep control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_now_q      <= '0;
			y_now_q      <= '0;
			x_prev_q     <= '0;
			y_prev_q     <= '0;
			depth_now_q  <= '0;
			have_x_q     <= 1'b0;
			have_y_q     <= 1'b0;
			first_pair_q <= 1'b1;
			fix_seen_q   <= 1'b0;
			idle_ticks_q <= '0;
			total_q      <= '0;
			deep_q       <= '0;
			leg_q        <= 1'b0;
		end else begin
			if (cmd.apply) begin
				x_now_q <= x_n;
				y_now_q <= y_n;
				leg_q   <= leg_now;
				case (pfo_action_t'(action))
					ACT_X, ACT_Y: begin
						fix_seen_q   <= 1'b1;
						idle_ticks_q <= '0;
					end
					ACT_DEPTH: depth_now_q <= value;
					ACT_TICK: begin
						if (fix_seen_q && !(&idle_ticks_q)) begin
							idle_ticks_q <= idle_ticks_q + 1'b1;
						end
					end
					default: ;
				endcase
				if (pair) begin
					first_pair_q <= 1'b0;
					x_prev_q     <= x_n;
					y_prev_q     <= y_n;
					have_x_q     <= 1'b0;
					have_y_q     <= 1'b0;
				end else begin
					have_x_q <= hx_n;
					have_y_q <= hy_n;
				end
			end
			// saturating leg accumulation
			if (cmd.acc) begin
				total_q <= sat_add(total_q, root_q);
				if (depth_now_q > depth_limit) begin
					deep_q <= sat_add(deep_q, root_q);
				end
			end
		end
	end

	// leg deltas, squares through one shared multiplier
	logic [POS_WIDTH-1:0] sq_op;
	logic [SQW-1:0]       sq_prod;

	assign sq_op   = cmd.sq_y ? dy_q : dx_q;
	assign sq_prod = SQW'(sq_op) * SQW'(sq_op);

	// one root bit per step
	logic [R+2:0] rem_t, trial, rem_diff;

	assign rem_t    = {rem_q, rad_q[RW-1:RW-2]};
	assign trial    = (R+3)'({root_q, 2'b01});
	assign rem_diff = rem_t - trial;

	// scaling through one shared 32 by 16 multiplier
	logic [63:0] tot64;
	logic [31:0] alt_op;
	logic [47:0] alt_prod;
	logic [64:0] alt_sum;
	logic        alt_sat;

	assign tot64    = 64'(total_q);
	assign alt_op   = cmd.alt_hi ? tot64[63:32] : tot64[31:0];
	assign alt_prod = 48'(alt_op) * 48'(cfg.alt_mult);
	assign alt_sum  = 65'({phi_q[39:0], 24'd0}) + 65'(plo_q[47:8]);
	assign alt_sat  = (|phi_q[47:40]) || alt_sum[64] || (alt_sum[63:0] > ACC_MAX64);

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			dx_q <= ddx[POS_WIDTH] ? POS_WIDTH'(-ddx) : ddx[POS_WIDTH-1:0];
			dy_q <= ddy[POS_WIDTH] ? POS_WIDTH'(-ddy) : ddy[POS_WIDTH-1:0];
		end
		if (cmd.sq_x) begin
			sqx_q <= sq_prod;
		end
		if (cmd.sq_y) begin
			sqy_q <= sq_prod;
		end
		if (cmd.sum) begin
			rad_q  <= RW'(sqx_q) + RW'(sqy_q);
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.root_step) begin
			rad_q <= {rad_q[RW-3:0], 2'b00};
			if (rem_t >= trial) begin
				rem_q  <= rem_diff[R:0];
				root_q <= {root_q[R-2:0], 1'b1};
			end else begin
				rem_q  <= rem_t[R:0];
				root_q <= {root_q[R-2:0], 1'b0};
			end
		end
		if (cmd.alt_lo) begin
			plo_q <= alt_prod;
		end
		if (cmd.alt_hi) begin
			phi_q <= alt_prod;
		end
		if (cmd.alt_sum) begin
			if (!cfg.alt_enable) begin
				alt_q <= '0;
			end else if (alt_sat) begin
				alt_q <= '1;
			end else begin
				alt_q <= alt_sum[ACC_WIDTH-1:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			leg_valid  <= leg_q;
			leg_len    <= leg_q ? root_q : '0;
			total_dist <= total_q;
			depth_dist <= deep_q;
			alt_total  <= alt_q;
			stale      <= fix_seen_q &&
				(CMPW'(idle_ticks_q) >= CMPW'(cfg.stale_limit));
		end
	end

endmodule

// ===== rtl/position_fix_odometer.sv =====
// Sequence: an item that completes a leg goes through the two squares, the sum, the
// bit-serial square root (one bit a cycle), the leg accumulation and the scaling steps
// before its result is loaded; any other item goes through the scaling steps only.
// An item is taken only while the controller is idle, so not before the last one is loaded;
// the next item is taken while a result waits in the output register.
// Reset: arst_n clears fix state, the distance and depth totals and the handshake; registers take their defaults.
`timescale 1ns / 1ps
module position_fix_odometer #(
	parameter int POS_WIDTH  = pfo_pkg::PFO_POS_WIDTH,
	parameter int ACC_WIDTH  = pfo_pkg::PFO_ACC_WIDTH,
	parameter int TICK_WIDTH = pfo_pkg::PFO_TICK_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pfo_pkg::PFO_ADDR_WIDTH-1:0] paddr,
	input  logic [pfo_pkg::PFO_DATA_WIDTH-1:0] pwdata,
	output logic [pfo_pkg::PFO_DATA_WIDTH-1:0] prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         action,
	input  logic signed [POS_WIDTH-1:0]        value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               leg_valid,
	output logic [POS_WIDTH:0]                 leg_len,
	output logic [ACC_WIDTH-1:0]               total_dist,
	output logic [ACC_WIDTH-1:0]               depth_dist,
	output logic [ACC_WIDTH-1:0]               alt_total,
	output logic                               stale
);
	import pfo_pkg::*;

	logic signed [POS_WIDTH-1:0] depth_limit;
	pfo_cfg_t                    cfg;
	pfo_cmd_t                    cmd;
	logic                        leg_now;

	// configuration registers
	pfo_regs #(
		.POS_WIDTH (POS_WIDTH)
	) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.depth_limit (depth_limit),
		.cfg         (cfg)
	);

	// sequencer
	pfo_ctrl #(
		.POS_WIDTH (POS_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.leg_now   (leg_now),
		.cmd       (cmd)
	);

	// arithmetic and state
	pfo_dp #(
		.POS_WIDTH  (POS_WIDTH),
		.ACC_WIDTH  (ACC_WIDTH),
		.TICK_WIDTH (TICK_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.depth_limit (depth_limit),
		.cfg         (cfg),
		.action      (action),
		.value       (value),
		.leg_now     (leg_now),
		.leg_valid   (leg_valid),
		.leg_len     (leg_len),
		.total_dist  (total_dist),
		.depth_dist  (depth_dist),
		.alt_total   (alt_total),
		.stale       (stale)
	);

endmodule

// ===== tb/position_fix_odometer_tb.sv =====
// self-checking testbench for the position fix odometer, with a built-in predictor
`timescale 1ns / 1ps
module position_fix_odometer_tb;
	import pfo_pkg::*;

	localparam int PW = PFO_POS_WIDTH;
	localparam int AW = PFO_ACC_WIDTH;
	localparam int TW = PFO_TICK_WIDTH;
	localparam logic [AW-1:0] ACC_FULL = '1;

	// one result item as the block should report it
	typedef struct {
		logic          leg_valid;
		logic [PW:0]   leg_len;
		logic [AW-1:0] total_dist;
		logic [AW-1:0] depth_dist;
		logic [AW-1:0] alt_total;
		logic          stale;
	} odo_report_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [PFO_ADDR_WIDTH-1:0] paddr = '0;
	logic [PFO_DATA_WIDTH-1:0] pwdata = '0;
	logic [PFO_DATA_WIDTH-1:0] prdata;
	logic                      pready;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [1:0]                action = '0;
	logic signed [PW-1:0]      value = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      leg_valid;
	logic [PW:0]               leg_len;
	logic [AW-1:0]             total_dist;
	logic [AW-1:0]             depth_dist;
	logic [AW-1:0]             alt_total;
	logic                      stale;

	// predicted navigation state
	logic signed [PW-1:0] x_cur = '0, y_cur = '0, x_last = '0, y_last = '0, depth_cur = '0;
	bit                   got_x = 0, got_y = 0, awaiting_first = 1, any_fix = 0;
	logic [AW-1:0]        sum_all = '0, sum_deep = '0;
	logic [TW-1:0]        ticks_idle = '0;

	// register copies, at their reset values
	logic signed [PW-1:0] deep_level = '0;
	logic [15:0]          stale_level = 16'd10;
	logic                 alt_on = 1'b0;
	logic [15:0]          alt_scale = 16'd256;

	odo_report_t pending_reports[$];
	int mismatches = 0;
	int items_taken = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_req = 0;
	int hold_left = 0;

	position_fix_odometer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.leg_valid (leg_valid),
		.leg_len   (leg_len),
		.total_dist(total_dist),
		.depth_dist(depth_dist),
		.alt_total (alt_total),
		.stale     (stale)
	);

	always #5 clk = ~clk;

	// floor square root, one bit at a time from the top
	function automatic logic [PW:0] leg_root(input logic [63:0] n);
		logic [31:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = {32'd0, r | (32'd1 << b)};
			if (t * t <= n) r = r | (32'd1 << b);
		end
		return r[PW:0];
	endfunction

	function automatic logic [AW-1:0] sat_sum(input logic [AW-1:0] a, input logic [PW:0] b);
		logic [AW:0] s;
		s = a + b;
		return s[AW] ? ACC_FULL : s[AW-1:0];
	endfunction

	// total times Q8.8 multiplier, saturated
	function automatic logic [AW-1:0] alt_scaled(input logic [AW-1:0] t, input logic [15:0] m);
		logic [AW+15:0] p;
		logic [AW+7:0]  q;
		p = t * m;
		q = p[AW+15:8];
		return (q > ACC_FULL) ? ACC_FULL : q[AW-1:0];
	endfunction

	// apply one accepted item and queue the result it should produce
	task automatic advance_odometer(input pfo_action_t act, input logic signed [PW-1:0] v);
		odo_report_t r;
		logic signed [PW:0] ddx, ddy;
		logic [63:0] mx, my;
		r.leg_valid = 1'b0;
		r.leg_len = '0;
		case (act)
			ACT_X: begin
				x_cur = v; got_x = 1; any_fix = 1; ticks_idle = '0;
			end
			ACT_Y: begin
				y_cur = v; got_y = 1; any_fix = 1; ticks_idle = '0;
			end
			ACT_DEPTH: depth_cur = v;
			default: if (any_fix && ticks_idle != '1) ticks_idle++;
		endcase
		if (got_x && got_y) begin
			if (awaiting_first) begin
				awaiting_first = 0;
			end else begin
				ddx = x_cur - x_last;
				ddy = y_cur - y_last;
				mx = (ddx < 0) ? -ddx : ddx;
				my = (ddy < 0) ? -ddy : ddy;
				r.leg_len = leg_root(mx * mx + my * my);
				r.leg_valid = 1'b1;
				sum_all = sat_sum(sum_all, r.leg_len);
				if (depth_cur > deep_level) sum_deep = sat_sum(sum_deep, r.leg_len);
			end
			x_last = x_cur;
			y_last = y_cur;
			got_x = 0;
			got_y = 0;
		end
		r.total_dist = sum_all;
		r.depth_dist = sum_deep;
		r.alt_total = alt_on ? alt_scaled(sum_all, alt_scale) : '0;
		r.stale = any_fix && (ticks_idle >= stale_level);
		pending_reports.push_back(r);
	endtask

	// offer one item, starting and ending at a falling edge
	task automatic send_item(input pfo_action_t act, input logic signed [PW-1:0] v);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		value <= v;
		do @(posedge clk); while (!in_ready);
		advance_odometer(act, v);
		items_taken++;
		@(negedge clk);
	endtask

	task automatic write_reg(input pfo_reg_t idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DEPTH_LIMIT: deep_level = data[PW-1:0];
			REG_STALE_LIMIT: stale_level = data[15:0];
			REG_ALT_ENABLE:  alt_on = data[0];
			REG_ALT_MULT:    alt_scale = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic signed [PW-1:0] thresh, input logic [15:0] stale_at,
			input logic en, input logic [15:0] mult);
		write_reg(REG_DEPTH_LIMIT, {{(32-PW){thresh[PW-1]}}, thresh});
		write_reg(REG_STALE_LIMIT, {16'd0, stale_at});
		write_reg(REG_ALT_ENABLE, {31'd0, en});
		write_reg(REG_ALT_MULT, {16'd0, mult});
	endtask

	// stop offering and wait until every result item is in, plus a margin
	task automatic drain_reports();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(negedge clk);
		repeat (PW + 16) @(negedge clk);
	endtask

	// coordinate near the last one, at an extreme, or anywhere
	function automatic logic signed [PW-1:0] pick_coord(input logic signed [PW-1:0] base);
		logic signed [PW-1:0] off;
		logic signed [PW-1:0] c;
		case ($urandom_range(7))
			0: c = $urandom_range(1) ? {1'b0, {(PW-1){1'b1}}} : {1'b1, {(PW-1){1'b0}}};
			1, 2, 3, 4: begin
				off = PW'($urandom_range(8191));
				c = base + off - PW'(4096);
			end
			default: c = PW'($urandom);
		endcase
		return c;
	endfunction

	// one short well-formed piece of traffic, sometimes a broken one
	task automatic send_random_run();
		int kind;
		logic signed [PW-1:0] a, b;
		kind = $urandom_range(99);
		a = pick_coord(x_cur);
		b = pick_coord(y_cur);
		if (kind < 68) begin
			if ($urandom_range(1)) begin
				send_item(ACT_X, a);
				send_item(ACT_Y, b);
			end else begin
				send_item(ACT_Y, b);
				send_item(ACT_X, a);
			end
		end else if (kind < 78) begin
			case ($urandom_range(3))
				0: a = deep_level - PW'(1);
				1: a = deep_level;
				2: a = deep_level + PW'(1);
				default: a = PW'($urandom);
			endcase
			send_item(ACT_DEPTH, a);
		end else if (kind < 90) begin
			repeat ($urandom_range(1, 4)) send_item(ACT_TICK, PW'($urandom));
		end else begin
			send_item($urandom_range(1) ? ACT_X : ACT_Y, a);
		end
	endtask

	task automatic send_runs(input int count);
		int start;
		start = items_taken;
		while (items_taken - start < count) send_random_run();
	endtask

	// first pair, repeated coordinates, extreme and zero legs, depth on both sides
	task automatic test_fix_pairs();
		send_item(ACT_TICK, '1);
		send_item(ACT_DEPTH, 24'sd0);
		send_item(ACT_X, 24'sd8388607);
		send_item(ACT_Y, -24'sd8388608);
		send_item(ACT_X, -24'sd8388608);
		send_item(ACT_X, 24'sd0);
		send_item(ACT_Y, 24'sd8388607);
		send_item(ACT_DEPTH, 24'sd1);
		send_item(ACT_Y, 24'sd8388607);
		send_item(ACT_X, 24'sd8388607);
		send_item(ACT_DEPTH, -24'sd8388608);
		send_item(ACT_X, -24'sd8388608);
		send_item(ACT_Y, -24'sd8388608);
		send_item(ACT_DEPTH, 24'sd8388607);
		send_item(ACT_X, -24'sd8388608);
		send_item(ACT_Y, -24'sd8388608);
		send_item(ACT_Y, 24'sd8388607);
		send_item(ACT_X, 24'sd8388607);
		drain_reports();
	endtask

	// idle ticks against the default, a threshold of one and a zero threshold
	task automatic test_stale_ticks();
		repeat (11) send_item(ACT_TICK, 24'sd0);
		send_item(ACT_Y, 24'sd5);
		drain_reports();
		configure(deep_level, 16'd1, 1'b0, 16'd256);
		send_item(ACT_TICK, 24'sd0);
		send_item(ACT_TICK, 24'sd0);
		drain_reports();
		configure(deep_level, 16'd0, 1'b0, 16'd256);
		send_item(ACT_DEPTH, 24'sd3);
		send_item(ACT_X, 24'sd77);
		drain_reports();
	endtask

	// a range of register settings, extremes among them
	task automatic test_register_settings();
		for (int s = 0; s < 5; s++) begin
			case (s)
				0: configure(-24'sd8388608, 16'd1, 1'b1, 16'hFFFF);
				1: configure(24'sd8388607, 16'hFFFF, 1'b1, 16'd0);
				2: configure(24'sd0, 16'd0, 1'b0, 16'd256);
				3: configure(PW'($urandom), 16'd3, 1'b1, 16'($urandom));
				default: configure(PW'($urandom), 16'($urandom_range(1, 20)), 1'b1, 16'd1);
			endcase
			send_runs(14);
			drain_reports();
		end
	endtask

	// random traffic under each idling mix
	task automatic test_random_traffic();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 88; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 88; end
				default: begin send_idle = 34; recv_stall = 34; end
			endcase
			configure(PW'($urandom), 16'($urandom_range(1, 30)), 1'($urandom_range(1)),
				16'($urandom));
			send_runs(100);
			drain_reports();
		end
		send_idle = 0;
		recv_stall = 0;
	endtask

	// output held off long enough to fill the block and stall its input
	task automatic test_output_hold();
		hold_req = 300;
		send_runs(30);
		drain_reports();
		send_runs(10);
		drain_reports();
	endtask

	// idle ticks run past a mid-range threshold, then a fix clears them
	task automatic test_tick_threshold();
		configure(deep_level, 16'd40, 1'b1, alt_scale);
		send_item(ACT_X, 24'sd1);
		repeat (45) send_item(ACT_TICK, PW'($urandom));
		send_item(ACT_Y, 24'sd2);
		drain_reports();
	endtask

	// output side: random stalls, or a long counted hold-off when asked
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// compare each result item with the oldest prediction
	always @(posedge clk) begin
		odo_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("result item with nothing expected");
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				if (leg_valid !== want.leg_valid) begin
					$error("leg_valid: expected %0d, got %0d", want.leg_valid, leg_valid);
					mismatches++;
				end
				if (leg_len !== want.leg_len) begin
					$error("leg_len: expected %0d, got %0d", want.leg_len, leg_len);
					mismatches++;
				end
				if (total_dist !== want.total_dist) begin
					$error("total_dist: expected %0d, got %0d", want.total_dist, total_dist);
					mismatches++;
				end
				if (depth_dist !== want.depth_dist) begin
					$error("depth_dist: expected %0d, got %0d", want.depth_dist, depth_dist);
					mismatches++;
				end
				if (alt_total !== want.alt_total) begin
					$error("alt_total: expected %0d, got %0d", want.alt_total, alt_total);
					mismatches++;
				end
				if (stale !== want.stale) begin
					$error("stale: expected %0d, got %0d", want.stale, stale);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_fix_pairs();
		test_stale_ticks();
		test_register_settings();
		test_random_traffic();
		test_output_hold();
		test_tick_threshold();
		if (mismatches == 0) begin
			$display("position_fix_odometer_tb: clean");
		end else begin
			$display("position_fix_odometer_tb: errors");
		end
		$finish;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("position_fix_odometer_tb: errors");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/pfo_pkg.sv
rtl/pfo_regs.sv
rtl/pfo_ctrl.sv
rtl/pfo_dp.sv
rtl/position_fix_odometer.sv
tb/position_fix_odometer_tb.sv
